/* rtl/mpct_pkg.sv */
// Shared types, constants and helpers of the mouse packet cursor tracker.
package mpct_pkg;

    // Configuration register indexes
    localparam logic C_CFG_GRID_COLUMNS = 1'b0;
    localparam logic C_CFG_GRID_ROWS    = 1'b1;

    // Reset values of the grid size registers
    localparam logic [7:0] C_GRID_COLUMNS_RST = 8'd80;
    localparam logic [7:0] C_GRID_ROWS_RST    = 8'd25;

    // Status byte checks
    localparam logic [7:0] C_STATUS_SYNC_BIT = 8'h08;
    localparam logic [7:0] C_STATUS_OVF_BITS = 8'hC0;

    // Delta shaping: halve above the threshold, then limit
    localparam logic [4:0] C_X_HALF_ABOVE = 5'd10;
    localparam logic [4:0] C_X_LIMIT      = 5'd20;
    localparam logic [4:0] C_Y_HALF_ABOVE = 5'd4;
    localparam logic [4:0] C_Y_LIMIT      = 5'd8;

    // Input beat: one mouse packet
    typedef struct packed {
        logic [7:0]        status_byte;
        logic signed [7:0] x_delta;
        logic signed [7:0] y_delta;
    } t_packet;

    // Output beat: new cursor place
    typedef struct packed {
        logic [7:0]  cursor_column;
        logic [7:0]  cursor_row;
        logic [15:0] cursor_index;
    } t_cursor;

    // Raw deltas of a packet that passed the toggle and status checks
    typedef struct packed {
        logic signed [7:0] x_delta;
        logic signed [7:0] y_delta;
    } t_motion;

    // Clamped cursor place and the column count it was clamped against
    typedef struct packed {
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] columns;
    } t_place;

    // Halve a magnitude above a threshold, then limit it; keep the sign.
    // A delta of -128 is taken as magnitude 128.
    function automatic logic signed [5:0] f_shape(
        input logic signed [7:0] d,
        input logic [4:0]        half_above,
        input logic [4:0]        limit
    );
        logic       neg;
        logic [8:0] wide;
        logic [7:0] mag;
        logic [5:0] lim;
        neg  = d[7];
        wide = neg ? 9'(-$signed({d[7], d})) : {1'b0, d};
        mag  = wide[7:0];
        if (mag > {3'b000, half_above}) begin
            mag = mag >> 1;
        end
        if (mag > {3'b000, limit}) begin
            mag = {3'b000, limit};
        end
        lim = mag[5:0];
        return neg ? -$signed(lim) : $signed(lim);
    endfunction

    // Clamp a signed position into 0 .. size-1 (size is at least one)
    function automatic logic [7:0] f_clamp(
        input logic signed [9:0] v,
        input logic [7:0]        size
    );
        logic [7:0] res;
        if (v < 10'sd0) begin
            res = 8'd0;
        end else if (v >= $signed({2'b00, size})) begin
            res = size - 8'd1;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

/* rtl/mpct_filter.sv */
// Input register: packet toggle and status checks.
module mpct_filter
    import mpct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_packet i_in_data,
    output logic    o_dn_valid,
    input  logic    i_dn_ready,
    output t_motion o_dn_data
);

    logic    r_process_next;
    logic    r_valid;
    t_motion r_motion;
    logic    n_process_next;
    logic    n_valid;
    logic    take;
    logic    keep;

    assign o_in_ready = !r_valid || i_dn_ready;
    assign take       = i_in_valid && o_in_ready;

    // Keep a processed packet with the sync bit set and not both overflows
    assign keep = r_process_next
               && ((i_in_data.status_byte & C_STATUS_SYNC_BIT) != 8'd0)
               && ((i_in_data.status_byte & C_STATUS_OVF_BITS) != C_STATUS_OVF_BITS);

    // Advance the toggle on every accepted beat; hold the stage until taken
    always_comb begin
        n_process_next = r_process_next;
        n_valid        = r_valid;
        if (take) begin
            n_process_next = !r_process_next;
            n_valid        = keep;
        end else if (i_dn_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_next <= 1'b1;
            r_valid        <= 1'b0;
        end else begin
            r_process_next <= n_process_next;
            r_valid        <= n_valid;
        end
    end

    // Capture the deltas
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_motion.x_delta <= i_in_data.x_delta;
            r_motion.y_delta <= i_in_data.y_delta;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_motion;

endmodule

/* rtl/mpct_move.sv */
// Cursor stage: delta shaping, position update and grid clamping.
module mpct_move
    import mpct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_grid_columns,
    input  logic [7:0] i_grid_rows,
    input  logic       i_up_valid,
    output logic       o_up_ready,
    input  t_motion    i_up_data,
    output logic       o_dn_valid,
    input  logic       i_dn_ready,
    output t_place     o_dn_data
);

    logic              r_valid;
    logic [7:0]        r_column;
    logic [7:0]        r_row;
    logic [7:0]        r_columns;
    logic              n_valid;
    logic signed [5:0] dx;
    logic signed [5:0] dy;
    logic [7:0]        cols;
    logic [7:0]        rows;
    logic signed [9:0] col_sum;
    logic signed [9:0] row_sum;
    logic              take;

    assign o_up_ready = !r_valid || i_dn_ready;
    assign take       = i_up_valid && o_up_ready;

    // Shape the deltas
    assign dx = f_shape(i_up_data.x_delta, C_X_HALF_ABOVE, C_X_LIMIT);
    assign dy = f_shape(i_up_data.y_delta, C_Y_HALF_ABOVE, C_Y_LIMIT);

    // Treat a zero grid size as one
    assign cols = (i_grid_columns == 8'd0) ? 8'd1 : i_grid_columns;
    assign rows = (i_grid_rows == 8'd0) ? 8'd1 : i_grid_rows;

    // Move right with X, up with Y (rows count down the screen)
    assign col_sum = $signed({2'b00, r_column}) + $signed({{4{dx[5]}}, dx});
    assign row_sum = $signed({2'b00, r_row}) - $signed({{4{dy[5]}}, dy});

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_dn_ready) begin
            n_valid = 1'b0;
        end
    end

    // Update the held cursor as the beat moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_column <= 8'd0;
            r_row    <= 8'd0;
        end else begin
            r_valid <= n_valid;
            if (take) begin
                r_column <= f_clamp(col_sum, cols);
                r_row    <= f_clamp(row_sum, rows);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_columns <= cols;
        end
    end

    assign o_dn_valid        = r_valid;
    assign o_dn_data.column  = r_column;
    assign o_dn_data.row     = r_row;
    assign o_dn_data.columns = r_columns;

endmodule

/* rtl/mpct_index.sv */
// Output register: linear cell index of the cursor.
module mpct_index
    import mpct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_up_valid,
    output logic    o_up_ready,
    input  t_place  i_up_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_cursor o_out_data
);

    logic        r_valid;
    t_cursor     r_data;
    logic        n_valid;
    logic [15:0] product;
    logic        take;

    assign o_up_ready = !r_valid || !i_out_stall;
    assign take       = i_up_valid && o_up_ready;

    // Row times columns
    assign product = {8'd0, i_up_data.row} * {8'd0, i_up_data.columns};

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data.cursor_column <= i_up_data.column;
            r_data.cursor_row    <= i_up_data.row;
            r_data.cursor_index  <= product + {8'd0, i_up_data.column};
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* rtl/mouse_packet_cursor_tracker.sv */
// Top level of the mouse packet cursor tracker.
// Takes one three-byte mouse packet per cycle unless o_in_stall is high,
// and moves a text-grid cursor. Every other packet is skipped, starting
// with the first one processed; a processed packet with status bit 3 clear
// or both overflow bits set gives no result. A kept packet gives one beat
// with the clamped column, row and the linear index row * columns + column.
// Throughput is one packet per clock while nothing stalls: the cursor
// update loop closes within the cursor stage. A result passes the input
// register, the cursor stage, the index multiply and the output register.
// Grid size registers reset to 80 by 25; a size of zero counts as one.
module mouse_packet_cursor_tracker
    import mpct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_packet    i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_cursor    o_out_data,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_grid_cols;
    logic [7:0] r_grid_rows;
    logic       in_ready;
    logic       mot_valid;
    logic       mot_ready;
    t_motion    mot_data;
    logic       place_valid;
    logic       place_ready;
    t_place     place_data;

    // Grid size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= C_GRID_COLUMNS_RST;
            r_grid_rows <= C_GRID_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_CFG_GRID_COLUMNS: r_grid_cols <= i_cfg_data;
                C_CFG_GRID_ROWS:    r_grid_rows <= i_cfg_data;
                default:            r_grid_rows <= r_grid_rows;
            endcase
        end
    end

    assign o_in_stall = !in_ready;

    mpct_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (i_in_data),
        .o_dn_valid (mot_valid),
        .i_dn_ready (mot_ready),
        .o_dn_data  (mot_data)
    );

    mpct_move u_move (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grid_columns (r_grid_cols),
        .i_grid_rows    (r_grid_rows),
        .i_up_valid     (mot_valid),
        .o_up_ready     (mot_ready),
        .i_up_data      (mot_data),
        .o_dn_valid     (place_valid),
        .i_dn_ready     (place_ready),
        .o_dn_data      (place_data)
    );

    mpct_index u_index (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_up_valid  (place_valid),
        .o_up_ready  (place_ready),
        .i_up_data   (place_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/mpct_checker.sv */
// Port-level checks of the mouse packet cursor tracker, bound to the top level.
module mpct_checker
    import mpct_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_cursor    o_out_data
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed or vanished");

    // On the top row the index equals the column
    a_top_row_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.cursor_row == 8'd0)
        |-> o_out_data.cursor_index == {8'd0, o_out_data.cursor_column})
        else $error("index does not match column on the top row");

    // The index never falls below the column
    a_index_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.cursor_index >= {8'd0, o_out_data.cursor_column})
        else $error("index below column");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (.*);
